[rtl/gffs_pkg.sv]
package gffs_pkg;
   localparam int MaxNonterms = 8;
   localparam int MaxProds = 16;
   localparam int MaxRhs = 4;
   localparam int NumTerms = 16;
   localparam int NtIdxW = 3;
   localparam int ProdIdxW = 4;
   localparam int ProdCntW = 5;
   localparam int SymW = 5;
   localparam int LenW = 3;
   localparam int SetW = 17;
   localparam int ProdW = NtIdxW + LenW + MaxRhs * SymW;
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;
   localparam logic [0:0] CSR_START = 1'b0;
   localparam logic [0:0] CSR_NUM = 1'b1;
   localparam int EpsBit = 16;
endpackage

[rtl/gffs_ram.sv]
module gffs_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/grammar_first_follow_sets_unit.sv]
// channel | dir | ports                                   | accepted when
// req     | in  | req_cmd lhs rhs_len sym0..sym3          | req_valid & !req_stall
// rsp     | out | rsp_nonterm first_set follow_set ...    | rsp_valid & !rsp_stall
// csr     | in  | csr_wr_en csr_index csr_wr_data         | csr_wr_en
// Clear and load are done in the idle state. Compute runs FIRST passes then FOLLOW passes
// over the production RAM, reading each production and then applying its update, with
// a closing step at the end of each pass, until a pass changes nothing; then it gives
// one result a cycle while rsp_stall is low.
// Reset is synchronous; the production RAM keeps its contents until written.
// A stalled result holds; no new item is taken until all results are out.
module grammar_first_follow_sets_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [2:0]  req_lhs,
   input  logic [2:0]  req_rhs_len,
   input  logic [4:0]  req_sym0,
   input  logic [4:0]  req_sym1,
   input  logic [4:0]  req_sym2,
   input  logic [4:0]  req_sym3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_nonterm,
   output logic [16:0] rsp_first_set,
   output logic [16:0] rsp_follow_set,
   output logic        rsp_dropped,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_wr_data
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FIRST = 3'd1;
   localparam logic [2:0] ST_FOLLOW = 3'd2;
   localparam logic [2:0] ST_EMIT = 3'd3;

   typedef logic [gffs_pkg::SetW-1:0] set_type;

   logic [2:0] state_ff, state_in;
   logic [gffs_pkg::ProdCntW-1:0] count_ff, count_in;
   logic overflow_ff, overflow_in;
   logic [2:0] start_ff;
   logic [3:0] num_ff;
   set_type first_ff [gffs_pkg::MaxNonterms];
   set_type follow_ff [gffs_pkg::MaxNonterms];
   logic [gffs_pkg::ProdCntW-1:0] pidx_ff, pidx_in;
   logic rdv_ff, rdv_in;
   logic changed_ff, changed_in;
   logic [2:0] eidx_ff, eidx_in;

   logic [3:0] n_act;
   logic wr_en;
   logic [gffs_pkg::ProdW-1:0] wr_data, rd_data;
   logic [gffs_pkg::ProdIdxW-1:0] rd_addr;
   logic [2:0] ld_len;

   always_comb begin
      n_act = num_ff;
      if (n_act == 4'd0) n_act = 4'd1;
      if (n_act > 4'(gffs_pkg::MaxNonterms)) n_act = 4'(gffs_pkg::MaxNonterms);
   end

   assign req_stall = (state_ff != ST_IDLE);
   wire acc = req_valid && !req_stall;

   always_comb begin
      ld_len = (req_rhs_len > 3'(gffs_pkg::MaxRhs)) ? 3'(gffs_pkg::MaxRhs) : req_rhs_len;
      wr_data = {req_lhs, ld_len,
                 (ld_len > 3'd3) ? req_sym3 : 5'd0, (ld_len > 3'd2) ? req_sym2 : 5'd0,
                 (ld_len > 3'd1) ? req_sym1 : 5'd0, (ld_len > 3'd0) ? req_sym0 : 5'd0};
   end
   assign wr_en = acc && req_cmd == gffs_pkg::CMD_LOAD
                  && count_ff < 5'(gffs_pkg::MaxProds);
   assign rd_addr = pidx_ff[gffs_pkg::ProdIdxW-1:0];

   gffs_ram #(.Width(gffs_pkg::ProdW), .Depth(gffs_pkg::MaxProds)) u_prod (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[gffs_pkg::ProdIdxW-1:0]),
      .wr_data(wr_data), .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // decode of the production read back
   logic [2:0] p_lhs, p_len;
   logic [4:0] p_sym [gffs_pkg::MaxRhs];
   logic       s_nt [gffs_pkg::MaxRhs];
   logic [2:0] s_idx [gffs_pkg::MaxRhs];
   set_type    s_add [gffs_pkg::MaxRhs];
   logic       s_null [gffs_pkg::MaxRhs];
   set_type first_add, fol_new [gffs_pkg::MaxNonterms];
   set_type suf_add [gffs_pkg::MaxRhs+1];
   logic    suf_null [gffs_pkg::MaxRhs+1];
   logic    all_null;

   always_comb begin
      p_lhs = rd_data[gffs_pkg::ProdW-1 -: 3];
      p_len = rd_data[gffs_pkg::ProdW-4 -: 3];
      for (int j = 0; j < gffs_pkg::MaxRhs; j++) begin
         p_sym[j] = rd_data[j*gffs_pkg::SymW +: gffs_pkg::SymW];
         s_nt[j] = p_sym[j][4] && ({1'b0, p_sym[j][2:0]} < n_act) && p_sym[j][3] == 1'b0;
         s_idx[j] = p_sym[j][2:0];
         if (s_nt[j]) begin
            s_add[j] = first_ff[s_idx[j]] & ~(set_type'(1) << gffs_pkg::EpsBit);
            s_null[j] = first_ff[s_idx[j]][gffs_pkg::EpsBit];
         end else begin
            s_add[j] = p_sym[j][4] ? '0 : (set_type'(1) << p_sym[j][3:0]);
            s_null[j] = 1'b0;
         end
      end
      // suffix scan from position q to end
      suf_add[gffs_pkg::MaxRhs] = '0;
      suf_null[gffs_pkg::MaxRhs] = 1'b1;
      for (int q = gffs_pkg::MaxRhs - 1; q >= 0; q--) begin
         if (3'(q) >= p_len) begin
            suf_add[q] = '0;
            suf_null[q] = 1'b1;
         end else begin
            suf_add[q] = s_add[q] | (s_null[q] ? suf_add[q+1] : '0);
            suf_null[q] = s_null[q] && suf_null[q+1];
         end
      end
      all_null = suf_null[0];
      first_add = suf_add[0] | (all_null ? (set_type'(1) << gffs_pkg::EpsBit) : '0);
      // follow: positions processed in order, later ones see earlier updates
      for (int i = 0; i < gffs_pkg::MaxNonterms; i++) fol_new[i] = follow_ff[i];
      for (int pos = 0; pos < gffs_pkg::MaxRhs; pos++) begin
         if (3'(pos) < p_len && s_nt[pos]) begin
            fol_new[s_idx[pos]] = fol_new[s_idx[pos]] | suf_add[pos+1]
               | (suf_null[pos+1] ? fol_new[p_lhs] : '0);
         end
      end
   end

   wire lhs_ok = {1'b0, p_lhs} < n_act;
   wire last_p = (pidx_ff == count_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      overflow_in = overflow_ff;
      pidx_in = pidx_ff;
      rdv_in = 1'b0;
      changed_in = changed_ff;
      eidx_in = eidx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               unique case (req_cmd)
                  gffs_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     overflow_in = 1'b0;
                  end
                  gffs_pkg::CMD_LOAD: begin
                     if (wr_en) count_in = count_ff + 5'd1;
                     else overflow_in = 1'b1;
                  end
                  gffs_pkg::CMD_COMPUTE: begin
                     state_in = ST_FIRST;
                     pidx_in = '0;
                     changed_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_FIRST, ST_FOLLOW: begin
            if (rdv_ff) begin
               pidx_in = pidx_ff + 5'd1;
            end else if (last_p) begin
               pidx_in = '0;
               changed_in = 1'b0;
               if (!changed_ff) begin
                  if (state_ff == ST_FIRST) state_in = ST_FOLLOW;
                  else begin
                     state_in = ST_EMIT;
                     eidx_in = '0;
                  end
               end
            end else begin
               rdv_in = 1'b1;
            end
            if (rdv_ff && lhs_ok) begin
               if (state_ff == ST_FIRST) begin
                  if ((first_ff[p_lhs] | first_add) != first_ff[p_lhs]) changed_in = 1'b1;
               end else begin
                  for (int i = 0; i < gffs_pkg::MaxNonterms; i++)
                     if (fol_new[i] != follow_ff[i]) changed_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               eidx_in = eidx_ff + 3'd1;
               if ({1'b0, eidx_ff} + 4'd1 == n_act) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         overflow_ff <= 1'b0;
         pidx_ff <= '0;
         rdv_ff <= 1'b0;
         changed_ff <= 1'b0;
         eidx_ff <= '0;
         start_ff <= 3'd0;
         num_ff <= 4'd4;
         for (int i = 0; i < gffs_pkg::MaxNonterms; i++) begin
            first_ff[i] <= '0;
            follow_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         overflow_ff <= overflow_in;
         pidx_ff <= pidx_in;
         rdv_ff <= rdv_in;
         changed_ff <= changed_in;
         eidx_ff <= eidx_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               gffs_pkg::CSR_START: start_ff <= csr_wr_data[2:0];
               gffs_pkg::CSR_NUM: num_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && acc && (req_cmd == gffs_pkg::CMD_CLEAR
             || req_cmd == gffs_pkg::CMD_COMPUTE)) begin
            // compute seeds the start nonterminal with the end marker
            for (int i = 0; i < gffs_pkg::MaxNonterms; i++) begin
               first_ff[i] <= '0;
               follow_ff[i] <= (req_cmd == gffs_pkg::CMD_COMPUTE
                                && {1'b0, start_ff} < n_act && 3'(i) == start_ff)
                               ? (set_type'(1) << gffs_pkg::EpsBit) : '0;
            end
         end
         if (rdv_ff && lhs_ok) begin
            if (state_ff == ST_FIRST) first_ff[p_lhs] <= first_ff[p_lhs] | first_add;
            else if (state_ff == ST_FOLLOW)
               for (int i = 0; i < gffs_pkg::MaxNonterms; i++) follow_ff[i] <= fol_new[i];
         end
      end
   end

   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_nonterm = eidx_ff;
   assign rsp_first_set = first_ff[eidx_ff];
   assign rsp_follow_set = follow_ff[eidx_ff];
   assign rsp_dropped = overflow_ff;
   assign rsp_last = ({1'b0, eidx_ff} + 4'd1 == n_act);
endmodule

[tb/tb_top.sv]
typedef struct packed {
   logic [2:0]  nonterm;
   logic [16:0] first_set;
   logic [16:0] follow_set;
   logic        dropped;
   logic        last;
} set_rsp_type;

class set_scoreboard;
   logic [2:0]  p_lhs [gffs_pkg::MaxProds];
   logic [2:0]  p_len [gffs_pkg::MaxProds];
   logic [4:0]  p_sym [gffs_pkg::MaxProds][gffs_pkg::MaxRhs];
   int          p_count;
   logic [16:0] first_tab [gffs_pkg::MaxNonterms];
   logic [16:0] follow_tab [gffs_pkg::MaxNonterms];
   bit          overflow;
   logic [2:0]  start_nt;
   logic [3:0]  nt_count;
   set_rsp_type pending [$];
   int          errors;
   int          checked;

   function new();
      p_count = 0;
      overflow = 0;
      start_nt = 0;
      nt_count = 4;
      errors = 0;
      checked = 0;
   endfunction

   function void write_reg(logic [0:0] idx, logic [3:0] val);
      if (idx == gffs_pkg::CSR_START) start_nt = val[2:0];
      else nt_count = val;
   endfunction

   function int nt_index(logic [4:0] s, int n);
      if (s >= 16 && s - 16 < n) return s - 16;
      return -1;
   endfunction

   function logic [16:0] term_mask(logic [4:0] s);
      if (s < gffs_pkg::NumTerms) return 17'd1 << s;
      return '0;
   endfunction

   // FIRST of symbols from position pos to end; bit 16 set when all nullable
   function logic [16:0] seq_first(int p, int pos, int n);
      logic [16:0] acc;
      int y;
      acc = '0;
      for (int j = pos; j < p_len[p]; j++) begin
         y = nt_index(p_sym[p][j], n);
         if (y < 0) return acc | term_mask(p_sym[p][j]);
         acc |= first_tab[y] & ~(17'd1 << gffs_pkg::EpsBit);
         if (!first_tab[y][gffs_pkg::EpsBit]) return acc;
      end
      return acc | (17'd1 << gffs_pkg::EpsBit);
   endfunction

   function void note_item(logic [1:0] cmd, logic [2:0] lhs, logic [2:0] len,
                           logic [4:0] s0, logic [4:0] s1, logic [4:0] s2,
                           logic [4:0] s3);
      logic [4:0] sv [4];
      logic [16:0] add;
      int n, a, x;
      bit changed;
      sv = '{s0, s1, s2, s3};
      if (cmd == gffs_pkg::CMD_CLEAR) begin
         p_count = 0;
         overflow = 0;
      end else if (cmd == gffs_pkg::CMD_LOAD) begin
         if (p_count >= gffs_pkg::MaxProds) overflow = 1;
         else begin
            p_lhs[p_count] = lhs;
            p_len[p_count] = (len > 3'(gffs_pkg::MaxRhs)) ? 3'(gffs_pkg::MaxRhs) : len;
            for (int j = 0; j < gffs_pkg::MaxRhs; j++)
               p_sym[p_count][j] = (j < p_len[p_count]) ? sv[j] : 5'd0;
            p_count++;
         end
      end else if (cmd == gffs_pkg::CMD_COMPUTE) begin
         n = (nt_count < 1) ? 1 : (nt_count > gffs_pkg::MaxNonterms) ?
             gffs_pkg::MaxNonterms : nt_count;
         for (int i = 0; i < gffs_pkg::MaxNonterms; i++) begin
            first_tab[i] = '0;
            follow_tab[i] = '0;
         end
         do begin
            changed = 0;
            for (int p = 0; p < p_count; p++) begin
               x = p_lhs[p];
               if (x >= n) continue;
               add = seq_first(p, 0, n);
               if ((first_tab[x] | add) != first_tab[x]) begin
                  first_tab[x] |= add;
                  changed = 1;
               end
            end
         end while (changed);
         if (start_nt < n) follow_tab[start_nt][gffs_pkg::EpsBit] = 1'b1;
         do begin
            changed = 0;
            for (int p = 0; p < p_count; p++) begin
               x = p_lhs[p];
               if (x >= n) continue;
               for (int pos = 0; pos < p_len[p]; pos++) begin
                  a = nt_index(p_sym[p][pos], n);
                  if (a < 0) continue;
                  add = seq_first(p, pos + 1, n);
                  if (add[gffs_pkg::EpsBit])
                     add = (add & ~(17'd1 << gffs_pkg::EpsBit)) | follow_tab[x];
                  if ((follow_tab[a] | add) != follow_tab[a]) begin
                     follow_tab[a] |= add;
                     changed = 1;
                  end
               end
            end
         end while (changed);
         for (int i = 0; i < n; i++)
            pending.push_back('{i[2:0], first_tab[i], follow_tab[i], overflow,
                                i == n - 1});
      end
   endfunction

   function void report(string what);
      errors++;
      $display("mismatch: %s", what);
   endfunction

   function void check_rsp(set_rsp_type got);
      set_rsp_type exp;
      checked++;
      if (pending.size() == 0) begin
         report($sformatf("unexpected result nonterm %0d", got.nonterm));
         return;
      end
      exp = pending.pop_front();
      if (got.nonterm != exp.nonterm)
         report($sformatf("nonterm %0d want %0d", got.nonterm, exp.nonterm));
      if (got.first_set != exp.first_set)
         report($sformatf("nt %0d first %h want %h", exp.nonterm, got.first_set,
                          exp.first_set));
      if (got.follow_set != exp.follow_set)
         report($sformatf("nt %0d follow %h want %h", exp.nonterm, got.follow_set,
                          exp.follow_set));
      if (got.dropped != exp.dropped)
         report($sformatf("nt %0d dropped %0d", exp.nonterm, got.dropped));
      if (got.last != exp.last)
         report($sformatf("nt %0d last %0d", exp.nonterm, got.last));
   endfunction
endclass

module tb_top;
   localparam logic [1:0] CmdUnknown = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_cmd = 0;
   logic [2:0]  req_lhs = 0;
   logic [2:0]  req_rhs_len = 0;
   logic [4:0]  req_sym0 = 0, req_sym1 = 0, req_sym2 = 0, req_sym3 = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_nonterm;
   logic [16:0] rsp_first_set, rsp_follow_set;
   logic        rsp_dropped, rsp_last;
   logic        csr_wr_en = 0;
   logic [0:0]  csr_index = 0;
   logic [3:0]  csr_wr_data = 0;

   set_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycles = 0;
   int items = 0;
   int computes = 0;

   grammar_first_follow_sets_unit u_top (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("timeout");
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_rsp('{rsp_nonterm, rsp_first_set, rsp_follow_set, rsp_dropped,
                        rsp_last});
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic send(logic [1:0] cmd, logic [2:0] lhs, logic [2:0] len,
                       logic [4:0] s0, logic [4:0] s1, logic [4:0] s2,
                       logic [4:0] s3);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_lhs <= lhs;
      req_rhs_len <= len;
      req_sym0 <= s0;
      req_sym1 <= s1;
      req_sym2 <= s2;
      req_sym3 <= s3;
      do @(posedge clock); while (req_stall);
      sb.note_item(cmd, lhs, len, s0, s1, s2, s3);
      items++;
      if (cmd == gffs_pkg::CMD_COMPUTE) computes++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [3:0] val);
      drain();
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.write_reg(idx, val);
   endtask

   function automatic logic [4:0] rand_sym(int n);
      int r;
      r = $urandom_range(99);
      if (r < 45) return 5'(16 + $urandom_range(n - 1));
      if (r < 90) return 5'($urandom_range(15));
      return 5'($urandom_range(31));
   endfunction

   task automatic rand_grammar(int nprods, int n);
      send(gffs_pkg::CMD_CLEAR, 3'($urandom), 3'($urandom), 5'($urandom),
           5'($urandom), 5'($urandom), 5'($urandom));
      for (int k = 0; k < nprods; k++) begin
         if ($urandom_range(9) == 0)
            send(CmdUnknown, 3'($urandom), 3'($urandom), 5'($urandom), 5'($urandom),
                 5'($urandom), 5'($urandom));
         send(gffs_pkg::CMD_LOAD, ($urandom_range(9) == 0) ? 3'($urandom) :
              3'($urandom_range(n - 1)),
              ($urandom_range(5) == 0) ? 3'd0 : 3'($urandom),
              rand_sym(n), rand_sym(n), rand_sym(n), rand_sym(n));
      end
      send(gffs_pkg::CMD_COMPUTE, 3'($urandom), 3'($urandom), 5'($urandom),
           5'($urandom), 5'($urandom), 5'($urandom));
   endtask

   initial begin
      int n;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // classic expression grammar, default settings (4 nonterminals)
      send(gffs_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0);
      send(gffs_pkg::CMD_LOAD, 0, 2, 5'd17, 5'd18, 0, 0);
      send(gffs_pkg::CMD_LOAD, 1, 3, 5'd0, 5'd17, 5'd18, 0);
      send(gffs_pkg::CMD_LOAD, 1, 0, 0, 0, 0, 0);
      send(gffs_pkg::CMD_LOAD, 2, 3, 5'd1, 5'd16, 5'd2, 0);
      send(gffs_pkg::CMD_LOAD, 2, 1, 5'd15, 0, 0, 0);
      send(gffs_pkg::CMD_LOAD, 3, 7, 5'd19, 5'd31, 5'd23, 5'd16);
      send(CmdUnknown, 7, 7, 31, 31, 31, 31);
      send(gffs_pkg::CMD_COMPUTE, 0, 0, 0, 0, 0, 0);
      // overflow: fill past capacity
      send(gffs_pkg::CMD_CLEAR, 7, 7, 31, 31, 31, 31);
      for (int k = 0; k < gffs_pkg::MaxProds + 1; k++)
         send(gffs_pkg::CMD_LOAD, 3'(k), 3'(k % 5), 5'(16 + k % 8), 5'(k), 5'd24,
              5'd16);
      send(gffs_pkg::CMD_COMPUTE, 7, 7, 31, 31, 31, 31);
      write_reg(gffs_pkg::CSR_NUM, 4'd0);
      send(gffs_pkg::CMD_COMPUTE, 0, 0, 0, 0, 0, 0);
      write_reg(gffs_pkg::CSR_NUM, 4'd15);
      write_reg(gffs_pkg::CSR_START, 4'd7);
      send(gffs_pkg::CMD_COMPUTE, 0, 0, 0, 0, 0, 0);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 56 : 0;
         recv_stall_pct = (ph == 2) ? 56 : 0;
         if (ph == 3) begin
            send_idle_pct = 9;
            recv_stall_pct = 9;
         end
         for (int g = 0; g < 5; g++) begin
            if (g % 2 == 0) begin
               write_reg(gffs_pkg::CSR_NUM, ($urandom_range(7) == 0) ? 4'($urandom) :
                         4'($urandom_range(1, 8)));
               write_reg(gffs_pkg::CSR_START, 4'($urandom_range(7)));
            end
            n = (sb.nt_count < 1) ? 1 : (sb.nt_count > 8) ? 8 : sb.nt_count;
            rand_grammar($urandom_range(2, 10), n);
         end
      end
      send_idle_pct = 0;
      drain();
      recv_stall_pct = 0;
      $display("covered %0d items, %0d computes, %0d results checked", items,
               computes, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

[files.f]
rtl/gffs_pkg.sv
rtl/gffs_ram.sv
rtl/grammar_first_follow_sets_unit.sv
tb/tb_top.sv
